/* hdl/psg_pkg.sv */
// Shared constants, register codes and the quarter-wave sine table
// for the periodic sine sample generator. No dependencies.
package psg_pkg;

	localparam int FREQ_W  = 16;
	localparam int AMP_W   = 11;
	localparam int CODE_W  = 12;
	localparam int CFG_W   = 16;
	localparam int PHASE_W = 10;
	localparam int SINE_W  = 16;
	localparam int PROD_W  = AMP_W + SINE_W;

	localparam logic [FREQ_W-1:0] FREQ_RESET = 16'd1000;
	localparam logic [AMP_W-1:0]  AMP_RESET  = 11'd1000;

	localparam logic [PROD_W-1:0] MID_SCALE_Q15 = 27'h400_0000;

	typedef enum logic [0:0] {
		REG_TONE_FREQUENCY = 1'b0,
		REG_TONE_AMPLITUDE = 1'b1
	} reg_index_t;

	typedef logic [256:0][SINE_W-1:0] qtab_t;

	localparam logic [63:0] PI_Q62 = 64'hC90F_DAA2_2168_C234;

	function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return p[125:62];
	endfunction

	function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
		logic [63:0] q;
		logic [64:0] r;
		q = '0;
		r = '0;
		for (int i = 63; i >= 0; i--) begin
			r = {r[63:0], n[i]};
			if (r >= {1'b0, d}) begin
				r = r - {1'b0, d};
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic qtab_t build_quarter();
		qtab_t t;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] den;
		logic [63:0] v;
		t = '0;
		for (int k = 0; k <= 256; k++) begin
			x = (PI_Q62 >> 9) * 64'(k);
			x2 = mul_q62(x, x);
			term = x;
			sum = x;
			for (int n = 1; n < 30; n++) begin
				if (term != 64'd0) begin
					den = 64'((2 * n) * (2 * n + 1));
					term = udiv64(mul_q62(term, x2), den);
					if (n[0]) begin
						sum = sum - term;
					end else begin
						sum = sum + term;
					end
				end
			end
			v = (((sum >> 30) * 64'd32767) + 64'h8000_0000) >> 32;
			t[k] = v[SINE_W-1:0];
		end
		return t;
	endfunction

	localparam qtab_t QUARTER = build_quarter();

endpackage

/* hdl/psg_div.sv */
// Restoring unsigned divider, one quotient bit per cycle.
// Uses no package; instantiated by periodic_sine_sample_generator_top.
module psg_div #(
	parameter int W  = 31,
	parameter int DW = 17
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [W-1:0]  dividend,
	input  logic [DW-1:0] divisor,
	output logic          done,
	output logic [W-1:0]  quotient
);

	localparam int CNT_W = $clog2(W + 1);

	logic [W-1:0]     dq_q;
	logic [DW-1:0]    rem_q;
	logic [DW-1:0]    d_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DW:0]      rem_sh;
	logic [DW:0]      rem_sub;
	logic             ge;

	assign rem_sh  = {rem_q, dq_q[W-1]};
	assign rem_sub = rem_sh - {1'b0, d_q};
	assign ge      = rem_sh >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= dividend;
			rem_q <= '0;
			d_q   <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
			dq_q  <= {dq_q[W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = dq_q;

endmodule

/* hdl/periodic_sine_sample_generator_top.sv */
// Periodic sine sample generator: every accepted input item (one sample tick or an idle
// poll) yields one 12-bit DAC code and a period-start flag. The period length is found
// by a one-bit-per-cycle divider, and the phase index comes from a reciprocal multiply
// registered in S_PHASE. After the input transfer the item waits in S_LEN for the
// divider, then passes S_PHASE, S_SINE and S_MULT, and S_OUT loads the result into the
// output register once no untaken earlier result holds it back. One item is in work
// at a time. in_stall is high from the input transfer until the result is loaded
// into the output register. That register may still hold an untaken result while the
// next item is accepted. Registers must be written over the plain cfg port only while
// the block is idle; the block itself does not enforce this. Depends on psg_pkg and psg_div.
module periodic_sine_sample_generator_top #(
	parameter int SAMPLE_RATE_HZ = 100000,
	parameter int BUFFER_DEPTH   = 2048
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [0:0]                  cfg_index,
	input  logic [psg_pkg::CFG_W-1:0]   cfg_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        sample_tick,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [psg_pkg::CODE_W-1:0]  dac_code,
	output logic                        period_start
);

	localparam int RATE_W    = $clog2(SAMPLE_RATE_HZ + 1);
	localparam int ACC_W     = RATE_W + 4;
	localparam int DIV_W     = RATE_W;
	localparam int DVS_W     = psg_pkg::FREQ_W;
	localparam int LEN_W     = $clog2(BUFFER_DEPTH + 1);
	localparam int IDX_W     = $clog2(BUFFER_DEPTH);
	localparam int PH_SH     = ACC_W + RATE_W;
	localparam logic [63:0] PH_MUL_WIDE =
		((64'd1 << (PH_SH + psg_pkg::PHASE_W)) + 64'(SAMPLE_RATE_HZ) - 64'd1) /
		64'(SAMPLE_RATE_HZ);
	localparam int MUL_W     = $clog2(PH_MUL_WIDE + 64'd1);
	localparam int PH_PROD_W = ACC_W + MUL_W;
	localparam logic [MUL_W-1:0] PH_MUL = PH_MUL_WIDE[MUL_W-1:0];

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_LEN   = 6'b000010,
		S_PHASE = 6'b000100,
		S_SINE  = 6'b001000,
		S_MULT  = 6'b010000,
		S_OUT   = 6'b100000
	} state_t;

	state_t                          state_q;
	logic [psg_pkg::FREQ_W-1:0]      freq_q;
	logic [psg_pkg::AMP_W-1:0]       amp_q;
	logic [IDX_W-1:0]                idx_q;
	logic [ACC_W-1:0]                acc_q;
	logic [LEN_W-1:0]                len_q;
	logic                            tick_q;
	logic [psg_pkg::PHASE_W-1:0]     phase_q;
	logic [psg_pkg::SINE_W-1:0]      mag_q;
	logic                            neg_q;
	logic [psg_pkg::PROD_W-1:0]      prod_q;
	logic                            out_valid_q;
	logic [psg_pkg::CODE_W-1:0]      dac_code_q;
	logic                            period_start_q;

	logic                            in_xfer;
	logic                            out_load;
	logic                            div_start;
	logic [DIV_W-1:0]                div_dividend;
	logic [DVS_W-1:0]                div_divisor;
	logic                            div_done;
	logic [DIV_W-1:0]                div_quot;
	logic [LEN_W-1:0]                len_c;
	logic                            prewrap_c;
	logic [PH_PROD_W-1:0]            ph_prod;
	logic [8:0]                      qaddr;
	logic [psg_pkg::PROD_W-1:0]      level;
	logic [LEN_W-1:0]                idx_nx;

	assign in_xfer  = in_valid && !in_stall;
	assign out_load = (state_q == S_OUT) && (!out_valid_q || !out_stall);

	always_comb begin
		if (32'(div_quot) > 32'(BUFFER_DEPTH)) begin
			len_c = LEN_W'(BUFFER_DEPTH);
		end else if (div_quot == '0) begin
			len_c = LEN_W'(1);
		end else begin
			len_c = LEN_W'(div_quot);
		end
		if (freq_q == '0) begin
			len_c = LEN_W'(BUFFER_DEPTH);
		end
	end

	assign prewrap_c = tick_q && (LEN_W'(idx_q) >= len_c);

	assign div_start    = in_xfer;
	assign div_dividend = DIV_W'(SAMPLE_RATE_HZ);
	assign div_divisor  = (freq_q == '0) ? DVS_W'(1) : freq_q;

	psg_div #(
		.W  (DIV_W),
		.DW (DVS_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quot)
	);

	assign ph_prod = PH_PROD_W'(acc_q) * PH_PROD_W'(PH_MUL);
	assign qaddr  = phase_q[8] ? (9'd256 - {1'b0, phase_q[7:0]}) : {1'b0, phase_q[7:0]};
	assign level  = neg_q ? (psg_pkg::MID_SCALE_Q15 - prod_q) : (psg_pkg::MID_SCALE_Q15 + prod_q);
	assign idx_nx = LEN_W'(idx_q) + LEN_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freq_q <= psg_pkg::FREQ_RESET;
			amp_q  <= psg_pkg::AMP_RESET;
		end else if (cfg_we) begin
			case (psg_pkg::reg_index_t'(cfg_index))
				psg_pkg::REG_TONE_FREQUENCY: freq_q <= cfg_data[psg_pkg::FREQ_W-1:0];
				psg_pkg::REG_TONE_AMPLITUDE: amp_q  <= cfg_data[psg_pkg::AMP_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= '0;
			acc_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						state_q <= S_LEN;
					end
				end
				S_LEN: begin
					if (div_done) begin
						if (prewrap_c) begin
							idx_q <= '0;
							acc_q <= '0;
						end
						state_q <= S_PHASE;
					end
				end
				S_PHASE: begin
					state_q <= S_SINE;
				end
				S_SINE: begin
					state_q <= S_MULT;
				end
				S_MULT: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_load) begin
						if (tick_q) begin
							if (idx_nx >= len_q) begin
								idx_q <= '0;
								acc_q <= '0;
							end else begin
								idx_q <= idx_nx[IDX_W-1:0];
								acc_q <= acc_q + ACC_W'(freq_q);
							end
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			tick_q <= sample_tick;
		end
		if ((state_q == S_LEN) && div_done) begin
			len_q <= len_c;
		end
		if (state_q == S_PHASE) begin
			phase_q <= ph_prod[PH_SH +: psg_pkg::PHASE_W];
		end
		if (state_q == S_SINE) begin
			mag_q <= psg_pkg::QUARTER[qaddr];
			neg_q <= phase_q[9];
		end
		if (state_q == S_MULT) begin
			prod_q <= psg_pkg::PROD_W'(amp_q) * psg_pkg::PROD_W'(mag_q);
		end
		if (out_load) begin
			dac_code_q     <= level[psg_pkg::PROD_W-1:15];
			period_start_q <= (idx_q == '0);
		end
	end

	assign in_stall     = (state_q != S_IDLE);
	assign out_valid    = out_valid_q;
	assign dac_code     = dac_code_q;
	assign period_start = period_start_q;

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_LEN))
		else $error("divider done outside a wait state");

	a_xfer_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> (state_q == S_LEN))
		else $error("input transfer did not start the period-length division");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && tick_q) |=> (LEN_W'(idx_q) < len_q))
		else $error("sample index left the period after advance");

	a_load_frees_input: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (out_valid_q && !in_stall))
		else $error("result load did not fill output and release input");

endmodule

/* bench/periodic_sine_sample_generator_top_tb.sv */
`timescale 1ns / 100ps
// Self-checking bench for periodic_sine_sample_generator_top: directed table, then random
// tick/poll transfers with register phases, checked against an in-bench sine predictor.
// Depends on psg_pkg and the generator RTL.
module periodic_sine_sample_generator_top_tb;

	localparam int unsigned RATE_HZ       = 100000;
	localparam int unsigned DEPTH         = 2048;
	localparam int          MID_Q15       = 1 << 26;
	localparam int          ITEM_TOTAL    = 1850;
	localparam int          SETTLE_CYCLES = 100;
	localparam int          HOLD_CYCLES   = 400;
	localparam int          CYCLE_LIMIT   = 1500000;

	typedef enum logic {ROW_TICK_ITEM, ROW_REG_WRITE} row_kind_t;

	typedef struct packed {
		row_kind_t                    kind;
		psg_pkg::reg_index_t          target;
		logic [psg_pkg::CFG_W-1:0]    value;
		logic                         tick;
		logic                         has_fixed;
		logic [psg_pkg::CODE_W-1:0]   code;
		logic                         start;
	} tone_row_t;

	typedef struct packed {
		logic [psg_pkg::CODE_W-1:0] code;
		logic                       start;
	} tone_sample_t;

	logic                        clk;
	logic                        arst_n;
	logic                        cfg_we;
	logic [0:0]                  cfg_index;
	logic [psg_pkg::CFG_W-1:0]   cfg_data;
	logic                        in_valid;
	logic                        in_stall;
	logic                        sample_tick;
	logic                        out_valid;
	logic                        out_stall;
	logic [psg_pkg::CODE_W-1:0]  dac_code;
	logic                        period_start;

	int          sine_quarter [0:256];
	int unsigned freq_cfg;
	int unsigned amp_cfg;
	int unsigned wave_index;
	int unsigned phase_acc;

	tone_sample_t dac_expect_q [$];
	int           mismatch_count;
	int           samples_requested;
	int           samples_checked;
	int           cycle_count;
	bit           quiet_tx;
	bit           quiet_rx;

	tone_row_t directed_rows [0:30] = '{
		'{ROW_TICK_ITEM, psg_pkg::REG_TONE_FREQUENCY, 16'd0,     1'b0, 1'b1, 12'd2048, 1'b1},
		'{ROW_TICK_ITEM, psg_pkg::REG_TONE_FREQUENCY, 16'd0,     1'b1, 1'b1, 12'd2048, 1'b1},
		'{ROW_TICK_ITEM, psg_pkg::REG_TONE_FREQUENCY, 16'd0,     1'b1, 1'b0, 12'd0,    1'b0},
		'{ROW_TICK_ITEM, psg_pkg::REG_TONE_FREQUENCY, 16'd0,     1'b0, 1'b0, 12'd0,    1'b0},
		'{ROW_TICK_ITEM, psg_pkg::REG_TONE_FREQUENCY, 16'd0,     1'b1, 1'b0, 12'd0,    1'b0},
		'{ROW_REG_WRITE, psg_pkg::REG_TONE_AMPLITUDE, 16'd2047,  1'b0, 1'b0, 12'd0,    1'b0},
		'{ROW_TICK_ITEM, psg_pkg::REG_TONE_FREQUENCY, 16'd0,     1'b1, 1'b0, 12'd0,    1'b0},
		'{ROW_TICK_ITEM, psg_pkg::REG_TONE_FREQUENCY, 16'd0,     1'b1, 1'b0, 12'd0,    1'b0},
		'{ROW_REG_WRITE, psg_pkg::REG_TONE_FREQUENCY, 16'd25000, 1'b0, 1'b0, 12'd0,    1'b0},
		'{ROW_TICK_ITEM, psg_pkg::REG_TONE_FREQUENCY, 16'd0,     1'b0, 1'b0, 12'd0,    1'b0},
		'{ROW_TICK_ITEM, psg_pkg::REG_TONE_FREQUENCY, 16'd0,     1'b1, 1'b1, 12'd2048, 1'b1},
		'{ROW_TICK_ITEM, psg_pkg::REG_TONE_FREQUENCY, 16'd0,     1'b1, 1'b0, 12'd0,    1'b0},
		'{ROW_TICK_ITEM, psg_pkg::REG_TONE_FREQUENCY, 16'd0,     1'b1, 1'b0, 12'd0,    1'b0},
		'{ROW_REG_WRITE, psg_pkg::REG_TONE_FREQUENCY, 16'd50000, 1'b0, 1'b0, 12'd0,    1'b0},
		'{ROW_TICK_ITEM, psg_pkg::REG_TONE_FREQUENCY, 16'd0,     1'b1, 1'b1, 12'd2048, 1'b1},
		'{ROW_TICK_ITEM, psg_pkg::REG_TONE_FREQUENCY, 16'd0,     1'b1, 1'b0, 12'd0,    1'b0},
		'{ROW_REG_WRITE, psg_pkg::REG_TONE_FREQUENCY, 16'd65535, 1'b0, 1'b0, 12'd0,    1'b0},
		'{ROW_TICK_ITEM, psg_pkg::REG_TONE_FREQUENCY, 16'd0,     1'b1, 1'b1, 12'd2048, 1'b1},
		'{ROW_TICK_ITEM, psg_pkg::REG_TONE_FREQUENCY, 16'd0,     1'b1, 1'b1, 12'd2048, 1'b1},
		'{ROW_TICK_ITEM, psg_pkg::REG_TONE_FREQUENCY, 16'd0,     1'b0, 1'b1, 12'd2048, 1'b1},
		'{ROW_REG_WRITE, psg_pkg::REG_TONE_FREQUENCY, 16'd0,     1'b0, 1'b0, 12'd0,    1'b0},
		'{ROW_TICK_ITEM, psg_pkg::REG_TONE_FREQUENCY, 16'd0,     1'b1, 1'b1, 12'd2048, 1'b1},
		'{ROW_TICK_ITEM, psg_pkg::REG_TONE_FREQUENCY, 16'd0,     1'b1, 1'b1, 12'd2048, 1'b0},
		'{ROW_TICK_ITEM, psg_pkg::REG_TONE_FREQUENCY, 16'd0,     1'b1, 1'b1, 12'd2048, 1'b0},
		'{ROW_REG_WRITE, psg_pkg::REG_TONE_AMPLITUDE, 16'd0,     1'b0, 1'b0, 12'd0,    1'b0},
		'{ROW_REG_WRITE, psg_pkg::REG_TONE_FREQUENCY, 16'd1,     1'b0, 1'b0, 12'd0,    1'b0},
		'{ROW_TICK_ITEM, psg_pkg::REG_TONE_FREQUENCY, 16'd0,     1'b1, 1'b1, 12'd2048, 1'b0},
		'{ROW_TICK_ITEM, psg_pkg::REG_TONE_FREQUENCY, 16'd0,     1'b1, 1'b1, 12'd2048, 1'b0},
		'{ROW_REG_WRITE, psg_pkg::REG_TONE_AMPLITUDE, 16'd2047,  1'b0, 1'b0, 12'd0,    1'b0},
		'{ROW_TICK_ITEM, psg_pkg::REG_TONE_FREQUENCY, 16'd0,     1'b1, 1'b0, 12'd0,    1'b0},
		'{ROW_TICK_ITEM, psg_pkg::REG_TONE_FREQUENCY, 16'd0,     1'b1, 1'b0, 12'd0,    1'b0}
	};

	periodic_sine_sample_generator_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.sample_tick  (sample_tick),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.dac_code     (dac_code),
		.period_start (period_start)
	);

	function automatic logic [63:0] q62_mul(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return p[125:62];
	endfunction

	function automatic void build_sine_quarter();
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] rounded;
		for (int k = 0; k <= 256; k++) begin
			x = (psg_pkg::PI_Q62 >> 9) * 64'(k);
			x2 = q62_mul(x, x);
			term = x;
			sum = x;
			for (int n = 1; n < 30 && term != 64'd0; n++) begin
				term = q62_mul(term, x2) / 64'((2 * n) * (2 * n + 1));
				if (n % 2 == 1) begin
					sum = sum - term;
				end else begin
					sum = sum + term;
				end
			end
			rounded = (((sum >> 30) * 64'd32767) + 64'h8000_0000) >> 32;
			sine_quarter[k] = int'(rounded);
		end
	endfunction

	function automatic tone_sample_t advance_tone(input logic tick);
		tone_sample_t s;
		int unsigned period_len;
		int unsigned phase_idx;
		int unsigned r;
		longint unsigned scaled;
		int sine_val;
		int v;
		period_len = (freq_cfg == 0) ? DEPTH : RATE_HZ / freq_cfg;
		if (period_len > DEPTH) begin
			period_len = DEPTH;
		end
		if (period_len == 0) begin
			period_len = 1;
		end
		if (tick && wave_index >= period_len) begin
			wave_index = 0;
			phase_acc = 0;
		end
		scaled = 64'(phase_acc) * 64'd1024;
		phase_idx = int'((scaled / 64'(RATE_HZ)) & 64'd1023);
		r = phase_idx & 255;
		case (phase_idx >> 8)
			0: sine_val = sine_quarter[r];
			1: sine_val = sine_quarter[256 - r];
			2: sine_val = -sine_quarter[r];
			default: sine_val = -sine_quarter[256 - r];
		endcase
		v = int'(amp_cfg) * sine_val + MID_Q15;
		if (v < 0) begin
			v = 0;
		end
		v = v >>> 15;
		if (v > 4095) begin
			v = 4095;
		end
		s.code = v[psg_pkg::CODE_W-1:0];
		s.start = (wave_index == 0);
		if (tick) begin
			wave_index++;
			if (wave_index >= period_len) begin
				wave_index = 0;
				phase_acc = 0;
			end else begin
				phase_acc += freq_cfg;
			end
		end
		return s;
	endfunction

	task automatic send_tick(input logic tick, input bit has_fixed, input tone_sample_t fixed);
		int gap;
		tone_sample_t s;
		gap = quiet_tx ? 0 : $urandom_range(0, 12);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		sample_tick <= tick;
		do @(posedge clk); while (in_stall);
		s = advance_tone(tick);
		dac_expect_q.push_back(has_fixed ? fixed : s);
		samples_requested++;
	endtask

	task automatic settle_block();
		@(negedge clk);
		in_valid <= 1'b0;
		while (dac_expect_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_register(input psg_pkg::reg_index_t target,
		input logic [psg_pkg::CFG_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= target;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (target == psg_pkg::REG_TONE_FREQUENCY) begin
			freq_cfg = value;
		end else begin
			amp_cfg = value & 16'h07FF;
		end
	endtask

	function automatic logic [psg_pkg::CFG_W-1:0] pick_frequency();
		int unsigned f;
		case ($urandom_range(0, 5))
			0: f = $urandom_range(0, 65535);
			1: f = $urandom_range(2000, 50000);
			2: f = $urandom_range(50, 2000);
			3: f = (freq_cfg > 8) ? freq_cfg - freq_cfg / 8 - 1 : $urandom_range(1, 65535);
			4: begin
				case ($urandom_range(0, 4))
					0: f = 0;
					1: f = 1;
					2: f = 49;
					3: f = 50000;
					default: f = 65535;
				endcase
			end
			default: f = $urandom_range(500, 5000);
		endcase
		return f[psg_pkg::CFG_W-1:0];
	endfunction

	function automatic logic [psg_pkg::CFG_W-1:0] pick_amplitude();
		case ($urandom_range(0, 5))
			0: return 16'd0;
			1: return 16'd2047;
			2: return 16'($urandom_range(0, 65535));
			default: return 16'($urandom_range(0, 2047));
		endcase
	endfunction

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("Regression FAIL");
		$finish;
	end

	initial begin : receiver
		int wait_left;
		tone_sample_t want;
		wait_left = 0;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				if (dac_expect_q.size() == 0) begin
					$error("unexpected transfer: dac_code %0d period_start %0d",
						dac_code, period_start);
					mismatch_count++;
				end else begin
					want = dac_expect_q.pop_front();
					if (dac_code !== want.code) begin
						$error("dac_code: expected %0d, got %0d", want.code, dac_code);
						mismatch_count++;
					end
					if (period_start !== want.start) begin
						$error("period_start: expected %0d, got %0d", want.start,
							period_start);
						mismatch_count++;
					end
				end
				samples_checked++;
				if (samples_checked % 64 == 0) begin
					quiet_rx = ($urandom_range(0, 3) == 0);
				end
				wait_left = quiet_rx ? 0 : $urandom_range(0, 12);
				if (samples_checked == 500) begin
					wait_left = HOLD_CYCLES;
				end
			end
			@(negedge clk);
			if (wait_left > 0) begin
				out_stall <= 1'b1;
				wait_left--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	initial begin : stimulus
		tone_row_t row;
		tone_sample_t fixed;
		int n;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		sample_tick = 1'b0;
		cycle_count = 0;
		mismatch_count = 0;
		samples_requested = 0;
		samples_checked = 0;
		quiet_tx = 1'b0;
		quiet_rx = 1'b0;
		freq_cfg = psg_pkg::FREQ_RESET;
		amp_cfg = psg_pkg::AMP_RESET;
		wave_index = 0;
		phase_acc = 0;
		build_sine_quarter();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			if (row.kind == ROW_REG_WRITE) begin
				settle_block();
				write_register(row.target, row.value);
			end else begin
				fixed.code = row.code;
				fixed.start = row.start;
				send_tick(row.tick, row.has_fixed, fixed);
			end
		end

		fixed = '0;
		while (samples_requested < ITEM_TOTAL) begin
			settle_block();
			if ($urandom_range(0, 3) != 0) begin
				write_register(psg_pkg::REG_TONE_FREQUENCY, pick_frequency());
			end
			if ($urandom_range(0, 1) == 0) begin
				write_register(psg_pkg::REG_TONE_AMPLITUDE, pick_amplitude());
			end
			quiet_tx = ($urandom_range(0, 3) == 0);
			n = $urandom_range(10, 160);
			repeat (n) send_tick($urandom_range(0, 7) != 0, 1'b0, fixed);
		end

		settle_block();
		if (mismatch_count == 0 && dac_expect_q.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
